// ===== sv/pdc_pkg.sv =====
// Shared types and constants for the PWM period/duty capture block.
package pdc_pkg;

  // Default width of the narrow timer counter
  localparam int NARROW_BITS_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDE_COUNTER = 2'd0;
  localparam logic [1:0] CFG_MIN_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_DUTY_LOW     = 2'd2;
  localparam logic [1:0] CFG_DUTY_HIGH    = 2'd3;

  localparam int CFG_DATA_BITS = 16;

  // Configuration reset values
  localparam logic        WIDE_COUNTER_RESET = 1'b0;
  localparam logic [15:0] MIN_PERIOD_RESET   = 16'd180;
  localparam logic [9:0]  DUTY_LOW_RESET     = 10'd10;
  localparam logic [9:0]  DUTY_HIGH_RESET    = 10'd990;

  // Event flag codes: bit0 update, bit1 leading capture, bit2 trailing capture
  localparam logic [2:0] FLAG_NONE       = 3'd0;
  localparam logic [2:0] FLAG_UPDATE     = 3'd1;
  localparam logic [2:0] FLAG_LEAD       = 3'd2;
  localparam logic [2:0] FLAG_LEAD_UPD   = 3'd3;
  localparam logic [2:0] FLAG_TRAIL      = 3'd4;
  localparam logic [2:0] FLAG_TRAIL_UPD  = 3'd5;
  localparam logic [2:0] FLAG_LEAD_TRAIL = 3'd6;
  localparam logic [2:0] FLAG_ALL        = 3'd7;

  // Reading status codes
  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_WRAPFIX  = 3'd1;
  localparam logic [2:0] ST_UNSYNCED = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_DUTY     = 3'd4;

  // Duty is scaled to thousandths; multiply runs one bit of the scale per step
  localparam int          DUTY_STEPS = 10;
  localparam logic [9:0]  DUTY_SCALE = 10'd1000;

  typedef enum logic [1:0] {
    PHASE_ERROR    = 2'd0,
    PHASE_LEADING  = 2'd1,
    PHASE_TRAILING = 2'd2
  } phase_t;

endpackage

// ===== sv/pwm_period_duty_capture.sv =====
// Top level of the PWM input capture block: period and high time per cycle.
//
// Channel   Dir  Handshake            Word
// in        in   in_valid/in_ready    event_flags, capture_full, capture_part
// out       out  out_valid/out_ready  full_period, part_period, reading_status
// cfg       in   cfg_we               cfg_index, cfg_data (write only)
//
// Busy: update and trailing-edge events leave the block idle. A leading edge ties
// it up until its reading is finished: unsynced and wide-mode readings go straight
// to finish, narrow mode runs the minimum and wrap checks, then the duty test: a
// 10-step shift-add multiply by 1000 and a 10-step restoring divide on the shared adder.
// Reset: rst (synchronous, active high) clears the sync phase, overflow counts and
// the output valid, and loads the configuration reset values.
// Stalls: a held output word does not block the input; only a new finished
// reading waits for the output register to free up.
module pwm_period_duty_capture #(
  parameter int NARROW_COUNTER_BITS = pdc_pkg::NARROW_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  event_flags,
  input  logic [31:0] capture_full,
  input  logic [31:0] capture_part,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] full_period,
  output logic [31:0] part_period,
  output logic [2:0]  reading_status,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int N  = NARROW_COUNTER_BITS;
  // Extended narrow count: 16 overflow bits over the counter bits
  localparam int PW = N + 16;
  // Reading registers: hold a wide capture or an extended count plus one wrap
  localparam int RW = (PW + 1 > 32) ? PW + 1 : 32;
  // Adder width: high time times the duty scale
  localparam int DW = PW + pdc_pkg::DUTY_STEPS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MIN    = 8'b0000_0010,
    S_WRAP   = 8'b0000_0100,
    S_FIX    = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_JUDGE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers
  logic        wide_counter;
  logic [15:0] min_period_count;
  logic [9:0]  duty_low_permille;
  logic [9:0]  duty_high_permille;

  // Sync state
  pdc_pkg::phase_t sync_phase;
  logic [15:0]     period_overflows;
  logic [15:0]     high_overflows;
  logic [15:0]     overflows_bumped;

  // Reading under work
  logic [RW-1:0] full_r;
  logic [RW-1:0] part_r;
  logic [2:0]    status_r;
  logic [DW-1:0] acc;
  logic [DW-1:0] opnd;
  logic [3:0]    cnt;
  logic [9:0]    quot;

  // Shared adder
  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_b;
  logic          alu_sub;
  logic [DW-1:0] alu_sum;
  logic          alu_carry;

  logic [31:0] full_sat;
  logic [31:0] part_sat;
  logic        out_free;
  logic        last_step;

  pdc_alu #(.W(DW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign last_step = (cnt == 4'(pdc_pkg::DUTY_STEPS - 1));

  // Saturating increment of the overflow count
  assign overflows_bumped = (period_overflows == 16'hFFFF) ? period_overflows
                                                           : period_overflows + 16'd1;

  // Clamp readings to the 32-bit output range
  assign full_sat = (full_r > RW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : full_r[31:0];
  assign part_sat = (part_r > RW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : part_r[31:0];

  // Steer the shared adder by sequencer step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_MIN: begin
        // full < min_period_count when no carry
        alu_a   = DW'(full_r);
        alu_b   = DW'(min_period_count);
        alu_sub = 1'b1;
      end
      S_WRAP: begin
        // full < part when no carry
        alu_a   = DW'(full_r);
        alu_b   = DW'(part_r);
        alu_sub = 1'b1;
      end
      S_FIX: begin
        // add one counter wrap
        alu_a   = DW'(full_r);
        alu_b   = DW'(1) << N;
      end
      S_MUL: begin
        alu_a   = acc;
        alu_b   = opnd;
      end
      S_DIV: begin
        alu_a   = acc;
        alu_b   = opnd;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_counter       <= pdc_pkg::WIDE_COUNTER_RESET;
      min_period_count   <= pdc_pkg::MIN_PERIOD_RESET;
      duty_low_permille  <= pdc_pkg::DUTY_LOW_RESET;
      duty_high_permille <= pdc_pkg::DUTY_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pdc_pkg::CFG_WIDE_COUNTER: wide_counter       <= cfg_data[0];
        pdc_pkg::CFG_MIN_PERIOD:   min_period_count   <= cfg_data[15:0];
        pdc_pkg::CFG_DUTY_LOW:     duty_low_permille  <= cfg_data[9:0];
        pdc_pkg::CFG_DUTY_HIGH:    duty_high_permille <= cfg_data[9:0];
        default:                   wide_counter       <= wide_counter;
      endcase
    end
  end

  // Sync tracking and reading sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sync_phase       <= pdc_pkg::PHASE_ERROR;
      period_overflows <= '0;
      high_overflows   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (event_flags)
              pdc_pkg::FLAG_UPDATE: begin
                period_overflows <= overflows_bumped;
              end
              pdc_pkg::FLAG_LEAD_UPD: begin
                sync_phase <= pdc_pkg::PHASE_LEADING;
                if (!wide_counter) begin
                  period_overflows <= '0;
                end
                if (sync_phase != pdc_pkg::PHASE_TRAILING) begin
                  full_r   <= '0;
                  part_r   <= '0;
                  status_r <= pdc_pkg::ST_UNSYNCED;
                  state    <= S_FINISH;
                end else if (wide_counter) begin
                  full_r   <= RW'(capture_full);
                  part_r   <= RW'(capture_part);
                  status_r <= pdc_pkg::ST_VALID;
                  state    <= S_FINISH;
                end else begin
                  // Extend the narrow captures by their overflow counts
                  full_r <= RW'({period_overflows, capture_full[N-1:0]});
                  part_r <= RW'({high_overflows, capture_part[N-1:0]});
                  state  <= S_MIN;
                end
              end
              pdc_pkg::FLAG_TRAIL, pdc_pkg::FLAG_TRAIL_UPD: begin
                if (sync_phase != pdc_pkg::PHASE_LEADING) begin
                  sync_phase <= pdc_pkg::PHASE_ERROR;
                end else if (event_flags == pdc_pkg::FLAG_TRAIL_UPD) begin
                  // Restore the overflow that came with the trailing edge
                  period_overflows <= overflows_bumped;
                  high_overflows   <= overflows_bumped;
                  sync_phase       <= pdc_pkg::PHASE_TRAILING;
                end else begin
                  high_overflows <= period_overflows;
                  sync_phase     <= pdc_pkg::PHASE_TRAILING;
                end
              end
              pdc_pkg::FLAG_LEAD, pdc_pkg::FLAG_LEAD_TRAIL, pdc_pkg::FLAG_ALL: begin
                sync_phase <= pdc_pkg::PHASE_ERROR;
              end
              default: begin
                sync_phase <= sync_phase;
              end
            endcase
          end
        end

        S_MIN: begin
          if (!alu_carry) begin
            full_r   <= '0;
            part_r   <= '0;
            status_r <= pdc_pkg::ST_SHORT;
            state    <= S_FINISH;
          end else begin
            state <= S_WRAP;
          end
        end

        S_WRAP: begin
          if (!alu_carry) begin
            state <= S_FIX;
          end else if (full_r == '0) begin
            // No period to divide by
            part_r   <= '0;
            status_r <= pdc_pkg::ST_DUTY;
            state    <= S_FINISH;
          end else begin
            acc   <= '0;
            opnd  <= DW'(part_r);
            cnt   <= '0;
            state <= S_MUL;
          end
        end

        S_FIX: begin
          full_r   <= RW'(alu_sum);
          status_r <= pdc_pkg::ST_WRAPFIX;
          state    <= S_FINISH;
        end

        S_MUL: begin
          // Accumulate high time shifted by each set bit of the scale
          if (pdc_pkg::DUTY_SCALE[cnt]) begin
            acc <= alu_sum;
          end
          if (last_step) begin
            opnd  <= DW'(full_r) << (pdc_pkg::DUTY_STEPS - 1);
            quot  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            opnd <= opnd << 1;
            cnt  <= cnt + 4'd1;
          end
        end

        S_DIV: begin
          // Restoring divide, one quotient bit per step, top bit first
          if (alu_carry) begin
            acc <= alu_sum;
          end
          quot <= {quot[8:0], alu_carry};
          opnd <= opnd >> 1;
          if (last_step) begin
            state <= S_JUDGE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end

        S_JUDGE: begin
          if (quot < duty_low_permille || quot > duty_high_permille) begin
            full_r   <= '0;
            part_r   <= '0;
            status_r <= pdc_pkg::ST_DUTY;
          end else begin
            status_r <= pdc_pkg::ST_VALID;
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load a finished reading, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      full_period    <= full_sat;
      part_period    <= part_sat;
      reading_status <= status_r;
    end
  end

endmodule

// ===== sv/pdc_alu.sv =====
// Shared add/subtract unit used by the capture sequencer.
module pdc_alu #(
  parameter int W = 42
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] total;

  // On subtract, carry high means a >= b
  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign sum   = total[W-1:0];
  assign carry = total[W];

endmodule

// ===== sv/pdc_checker.sv =====
// Port-level checks for the PWM capture block, bound to its top level.
module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  event_flags,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] full_period,
  input logic [31:0] part_period,
  input logic [2:0]  reading_status
);

  // A held output word must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(full_period)
      && $stable(part_period) && $stable(reading_status))
    else $error("output word changed while stalled");

  // Rejected readings carry zero periods
  a_zero_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reading_status == pdc_pkg::ST_UNSYNCED
      || reading_status == pdc_pkg::ST_SHORT || reading_status == pdc_pkg::ST_DUTY)
    |-> full_period == 32'd0 && part_period == 32'd0)
    else $error("rejected reading with nonzero period");

  // A leading edge starts work, so the input closes the next cycle
  a_lead_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && event_flags == pdc_pkg::FLAG_LEAD_UPD |=> !in_ready)
    else $error("input still open after a leading edge");

  // No output word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind pwm_period_duty_capture pdc_checker u_pdc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .event_flags    (event_flags),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .full_period    (full_period),
  .part_period    (part_period),
  .reading_status (reading_status)
);

// ===== sim/pwm_period_duty_capture_tb.sv =====
// Self-checking testbench for the PWM period/duty capture block.
module pwm_period_duty_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int NB = NARROW_BITS_DEFAULT;
  localparam logic [63:0] NARROW_MASK = (64'd1 << NB) - 64'd1;
  localparam logic [63:0] NARROW_WRAP = 64'd1 << NB;

  // Cycles to hold off after the last reading before touching registers or ending.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no word moving on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [31:0] full_period;
    logic [31:0] part_period;
    logic [2:0]  reading_status;
  } reading_t;

  localparam reading_t NO_READING = '0;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

  // For ROW_REG rows cf carries the register index and cp the write data.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  flags;
    logic [31:0] cf;
    logic [31:0] cp;
    logic        pinned;
    reading_t    want;
  } stim_row_t;

  // Directed walk, starting from reset configuration (narrow, 180, 10, 990).
  // Rows with pinned set carry a reading worked out by hand; the others are
  // checked against the predictor.
  localparam stim_row_t DIRECTED [36] = '{
    // empty event: nothing happens
    '{ROW_EVENT, FLAG_NONE,       32'hDEAD_BEEF, 32'h1234_5678, 1'b0, NO_READING},
    // first leading edge after reset cannot be synced
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, 32'd0, ST_UNSYNCED}},
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    // plain 50% reading
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h1F4,       1'b1,
      '{32'd1000, 32'd500, ST_VALID}},
    // two overflows, then a trailing edge with its own overflow
    '{ROW_EVENT, FLAG_UPDATE,     32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_UPDATE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_READING},
    '{ROW_EVENT, FLAG_TRAIL_UPD,  32'h0,         32'h0,         1'b0, NO_READING},
    // extended period below extended high time: wrap fix
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'hFFFF_0010, 32'h0000_8000, 1'b0, NO_READING},
    // period under the minimum
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h64,        32'h32,        1'b1,
      '{32'd0, 32'd0, ST_SHORT}},
    // duty far too low
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h2710,      32'h5,         1'b1,
      '{32'd0, 32'd0, ST_DUTY}},
    // duty just too high
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h3E7,       1'b1,
      '{32'd0, 32'd0, ST_DUTY}},
    // lone leading edge breaks sync
    '{ROW_EVENT, FLAG_LEAD,       32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h1F4,       1'b1,
      '{32'd0, 32'd0, ST_UNSYNCED}},
    // both edges at once break sync; a trailing edge cannot repair it
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_TRAIL, 32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h1F4,       1'b1,
      '{32'd0, 32'd0, ST_UNSYNCED}},
    // all flags at once break sync
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_ALL,        32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h1F4,       1'b1,
      '{32'd0, 32'd0, ST_UNSYNCED}},
    // no minimum and a zero period: no duty can be formed
    '{ROW_REG,   FLAG_NONE,       {30'd0, CFG_MIN_PERIOD},   32'd0, 1'b0, NO_READING},
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'hFFFF_0000, 32'hABCD_0000, 1'b1,
      '{32'd0, 32'd0, ST_DUTY}},
    // wide counter: counts pass through whole
    '{ROW_REG,   FLAG_NONE,       {30'd0, CFG_WIDE_COUNTER}, 32'd1, 1'b0, NO_READING},
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'hFFFF_FFFF, 32'h8000_0001, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, ST_VALID}},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
      '{32'd0, 32'd0, ST_UNSYNCED}},
    // back to narrow with the reset minimum
    '{ROW_REG,   FLAG_NONE,       {30'd0, CFG_WIDE_COUNTER}, 32'd0, 1'b0, NO_READING},
    '{ROW_REG,   FLAG_NONE,       {30'd0, CFG_MIN_PERIOD},   32'd180, 1'b0, NO_READING},
    // duty exactly on each bound is still valid
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'h3DE,       1'b1,
      '{32'd1000, 32'd990, ST_VALID}},
    '{ROW_EVENT, FLAG_TRAIL,      32'h0,         32'h0,         1'b0, NO_READING},
    '{ROW_EVENT, FLAG_LEAD_UPD,   32'h3E8,       32'hA,         1'b1,
      '{32'd1000, 32'd10, ST_VALID}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  event_flags = FLAG_NONE;
  logic [31:0] capture_full = '0;
  logic [31:0] capture_part = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] full_period;
  logic [31:0] part_period;
  logic [2:0]  reading_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDE_COUNTER;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor copy of the configuration and capture state
  logic        cfg_wide = WIDE_COUNTER_RESET;
  logic [15:0] cfg_min_period = MIN_PERIOD_RESET;
  logic [9:0]  cfg_duty_low = DUTY_LOW_RESET;
  logic [9:0]  cfg_duty_high = DUTY_HIGH_RESET;
  phase_t      sync_now = PHASE_ERROR;
  logic [15:0] period_ovf = '0;
  logic [15:0] high_ovf = '0;

  reading_t pending_readings[$];

  bit stalls_on = 1'b1;
  int out_hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int readings_checked = 0;
  int settings_used = 0;
  int status_seen [5] = '{default: 0};

  pwm_period_duty_capture #(
    .NARROW_COUNTER_BITS(NB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .event_flags(event_flags),
    .capture_full(capture_full),
    .capture_part(capture_part),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .full_period(full_period),
    .part_period(part_period),
    .reading_status(reading_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advance the capture state by one event; return 1 with the reading when
  // the event closes a cycle (leading edge together with update).
  function automatic logic capture_step(input logic [2:0] flags, input logic [31:0] cf,
                                        input logic [31:0] cp, output reading_t rd);
    logic [63:0] full_ext;
    logic [63:0] part_ext;
    logic [63:0] duty;
    logic [2:0]  st;
    logic        made;
    made = 1'b0;
    rd = NO_READING;
    case (flags)
      FLAG_UPDATE: period_ovf = sat_inc16(period_ovf);
      FLAG_TRAIL, FLAG_TRAIL_UPD: begin
        if (sync_now != PHASE_LEADING) begin
          sync_now = PHASE_ERROR;
        end else begin
          // the overflow riding on the trailing edge belongs to the high time
          if (flags == FLAG_TRAIL_UPD) period_ovf = sat_inc16(period_ovf);
          high_ovf = period_ovf;
          sync_now = PHASE_TRAILING;
        end
      end
      FLAG_LEAD, FLAG_LEAD_TRAIL, FLAG_ALL: sync_now = PHASE_ERROR;
      FLAG_LEAD_UPD: begin
        made = 1'b1;
        full_ext = '0;
        part_ext = '0;
        st = ST_UNSYNCED;
        if (sync_now == PHASE_TRAILING) begin
          if (cfg_wide) begin
            full_ext = 64'(cf);
            part_ext = 64'(cp);
            st = ST_VALID;
          end else begin
            full_ext = (cf & NARROW_MASK) + (period_ovf << NB);
            part_ext = (cp & NARROW_MASK) + (high_ovf << NB);
            if (full_ext < cfg_min_period) begin
              full_ext = '0;
              part_ext = '0;
              st = ST_SHORT;
            end else if (full_ext < part_ext) begin
              full_ext = full_ext + NARROW_WRAP;
              st = ST_WRAPFIX;
            end else if (full_ext == 0) begin
              part_ext = '0;
              st = ST_DUTY;
            end else begin
              duty = (part_ext * DUTY_SCALE) / full_ext;
              if (duty < cfg_duty_low || duty > cfg_duty_high) begin
                full_ext = '0;
                part_ext = '0;
                st = ST_DUTY;
              end else begin
                st = ST_VALID;
              end
            end
          end
        end
        // wide mode keeps the overflow count running across cycles
        if (!cfg_wide) period_ovf = '0;
        rd.full_period = (full_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : full_ext[31:0];
        rd.part_period = (part_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : part_ext[31:0];
        rd.reading_status = st;
        sync_now = PHASE_LEADING;
      end
      default: ;
    endcase
    return made;
  endfunction

  // Offer one event word, optionally after an idle burst, and hold it until
  // taken. A pinned reading replaces the predicted one in the queue.
  task automatic send_word(input logic [2:0] flags, input logic [31:0] cf,
                           input logic [31:0] cp, input logic pinned, input reading_t want);
    reading_t predicted;
    logic     made;
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    event_flags <= flags;
    capture_full <= cf;
    capture_part <= cp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = capture_step(flags, cf, cp, predicted);
    if (made) pending_readings.push_back(pinned ? want : predicted);
    if (flags != FLAG_NONE) words_sent++;
  endtask

  // Drop valid, wait out every pending reading plus the block's latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_WIDE_COUNTER: cfg_wide = data[0];
      CFG_MIN_PERIOD:   cfg_min_period = data;
      CFG_DUTY_LOW:     cfg_duty_low = data[9:0];
      CFG_DUTY_HIGH:    cfg_duty_high = data[9:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Load all four registers; stuff junk above the wide-counter and duty widths.
  task automatic apply_settings(input logic wide, input logic [15:0] min_period,
                                input logic [9:0] duty_low, input logic [9:0] duty_high);
    logic [31:0] junk;
    junk = $urandom();
    settle();
    write_reg(CFG_WIDE_COUNTER, {junk[14:0], wide});
    write_reg(CFG_MIN_PERIOD, min_period);
    write_reg(CFG_DUTY_LOW, {junk[20:15], duty_low});
    write_reg(CFG_DUTY_HIGH, {junk[26:21], duty_high});
    settings_used++;
  endtask

  // Mostly well-formed cycles (overflows, trailing edge, overflows, leading
  // edge) with random counts; the rest is noise over every flag code.
  task automatic random_cycles(input int n_words);
    int          start_count;
    int          u_before;
    int          u_after;
    int          k;
    logic [2:0]  noise_flags;
    logic [15:0] lo_full;
    logic [15:0] lo_part;
    logic [31:0] cf;
    logic [31:0] cp;
    start_count = words_sent;
    while (words_sent - start_count < n_words) begin
      if ($urandom_range(0, 99) < 85) begin
        u_before = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : $urandom_range(0, 1);
        u_after = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : $urandom_range(0, 1);
        for (k = 0; k < u_before; k++) send_word(FLAG_UPDATE, $urandom(), $urandom(), 1'b0, '0);
        send_word($urandom_range(0, 1) ? FLAG_TRAIL_UPD : FLAG_TRAIL, $urandom(), $urandom(),
                  1'b0, '0);
        for (k = 0; k < u_after; k++) send_word(FLAG_UPDATE, $urandom(), $urandom(), 1'b0, '0);
        // bias toward plausible duty, with short periods now and then
        lo_full = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 400))
                                              : 16'($urandom_range(0, 65535));
        lo_part = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, lo_full))
                                              : 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 15) == 0) lo_part = lo_full;
        cf = $urandom();
        cp = $urandom();
        cf[15:0] = lo_full;
        cp[15:0] = lo_part;
        send_word(FLAG_LEAD_UPD, cf, cp, 1'b0, '0);
      end else begin
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          noise_flags = 3'($urandom_range(0, 7));
          send_word(noise_flags, $urandom(), $urandom(), 1'b0, '0);
        end
      end
    end
  endtask

  // Receiver: accept readings, stalling in random bursts while allowed.
  always @(posedge clk) begin
    if (out_hold_left > 0) out_hold_left--;
    else if (stalls_on && $urandom_range(0, 7) == 0) out_hold_left = $urandom_range(1, 16);
    out_ready <= (out_hold_left == 0);
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
  endtask

  // Compare each reading taken against the oldest one predicted.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: reading with none expected: full %h part %h status %0d",
                   $time, full_period, part_period, reading_status);
      end else begin
        want = pending_readings.pop_front();
        if (want.full_period !== full_period)
          report_field("full_period", want.full_period, full_period);
        if (want.part_period !== part_period)
          report_field("part_period", want.part_period, part_period);
        if (want.reading_status !== reading_status)
          report_field("reading_status", {29'd0, want.reading_status}, {29'd0, reading_status});
        readings_checked++;
        if (reading_status < 5) status_seen[reading_status]++;
      end
    end
  end

  // Watchdog: abandon the run when no word moves on either channel too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d readings outstanding",
               $time, WATCHDOG_LIMIT, pending_readings.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [15:0] rand_min;
    logic [9:0]  rand_low;
    logic [9:0]  rand_high;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed walk: reset values first, then the rows' own register writes
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[i].cf[1:0], DIRECTED[i].cp[15:0]);
      end else begin
        send_word(DIRECTED[i].flags, DIRECTED[i].cf, DIRECTED[i].cp,
                  DIRECTED[i].pinned, DIRECTED[i].want);
      end
    end

    // Random phases over a spread of register settings
    random_cycles(80);
    apply_settings(1'b0, 16'd0, 10'd0, 10'd1000);
    random_cycles(80);
    apply_settings(1'b1, MIN_PERIOD_RESET, DUTY_LOW_RESET, DUTY_HIGH_RESET);
    random_cycles(80);
    apply_settings(1'b0, 16'hFFFF, 10'd1000, 10'd1000);
    random_cycles(60);
    rand_min = 16'($urandom_range(0, 3000));
    rand_low = 10'($urandom_range(0, 400));
    rand_high = 10'($urandom_range(600, 1000));
    apply_settings(1'b0, rand_min, rand_low, rand_high);
    random_cycles(80);

    // Last stretch at reset settings with both sides running flat out
    stalls_on = 1'b0;
    apply_settings(WIDE_COUNTER_RESET, MIN_PERIOD_RESET, DUTY_LOW_RESET, DUTY_HIGH_RESET);
    random_cycles(100);

    settle();
    $display("Sent %0d event words and checked %0d readings over %0d register settings.",
             words_sent, readings_checked, settings_used + 1);
    $display("Statuses seen: valid %0d, wrap fix %0d, unsynced %0d, short %0d, duty %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pdc_pkg.sv
sv/pdc_alu.sv
sv/pwm_period_duty_capture.sv
sv/pdc_checker.sv
sim/pwm_period_duty_capture_tb.sv
